/* design/pdrb_pkg.sv */
package pdrb_pkg;

   localparam int unsigned IDX_W = 3;
   localparam int unsigned CUR_W = 14;
   localparam int unsigned VQ_W  = 15;
   localparam int unsigned PROD_W = 31;
   localparam int unsigned RECIP_SHIFT = 20;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DIRECT = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] KIND_FIXED = 2'd0;
   localparam logic [1:0] KIND_PPS   = 2'd3;

   localparam logic [15:0] MIN_CURRENT = 16'd25;

   // ceil(2^20 / d): exact floor division over the bounded operands used here
   localparam logic [16:0] RECIP_10 = 17'd104858;
   localparam logic [16:0] RECIP_20 = 17'd52429;
   localparam logic [16:0] RECIP_50 = 17'd20972;

   localparam logic [CUR_W-1:0] RND_10 = 14'd5;
   localparam logic [CUR_W-1:0] RND_50 = 14'd25;
   localparam logic [VQ_W-1:0]  RND_20 = 15'd10;

   typedef struct packed {
      logic [1:0]       kind;
      logic [2:0]       pos;
      logic [CUR_W-1:0] imax;
      logic [15:0]      vmax;
      logic [15:0]      vmin;
   } entry_type;

   typedef struct packed {
      logic             direct;
      logic [IDX_W-1:0] tidx;
      logic [15:0]      v;
      logic [15:0]      i;
      logic             fix_hit;
      logic [IDX_W-1:0] fix_idx;
      entry_type        fix_e;
      logic             pps_hit;
      logic [IDX_W-1:0] pps_idx;
      entry_type        pps_e;
   } token_type;

   typedef struct packed {
      logic a_vld;
      logic b_vld;
   } build_status_type;

   function automatic entry_type decode_pdo(input logic [31:0] w, input logic [2:0] pos);
      entry_type e;
      e.kind = w[31:30];
      e.pos  = pos;
      if (w[31:30] == KIND_PPS) begin
         e.imax = CUR_W'(w[6:0] * 13'd50);
         e.vmin = 16'(w[15:8] * 16'd100);
         e.vmax = 16'(w[24:17] * 16'd100);
      end else begin
         e.imax = CUR_W'(w[9:0] * 14'd10);
         e.vmin = 16'(w[19:10] * 16'd50);
         e.vmax = (w[31:30] == KIND_FIXED) ? 16'(w[19:10] * 16'd50)
                                           : 16'(w[29:20] * 16'd50);
      end
      return e;
   endfunction

endpackage

/* design/usb_pd_source_cap_request_builder_top.sv */
// Channel  Direction  Handshake            Beat contents
// req      in         req_valid/req_stall  op, first, pdo_word, target_index, voltage, current
// rsp      out        rsp_valid/rsp_stall  request_word, found, chosen_index, granted V and I
//
// A capability load never raises req_stall; loads may run back to back.
// A search or direct request walks the cell row one cell per cycle, then passes the select,
// reciprocal multiply and output stages on the way to its response beat.
// Synchronous active-high reset clears the counts and all stage valids; no clearing pass.
// req_stall is high while a request is inside the row or the build stages; the output
// register lets the next beat in while a finished response waits on rsp_stall.
module usb_pd_source_cap_request_builder_top #(
   parameter int unsigned MAX_CAPS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic        req_first,
   input  logic [31:0] req_pdo_word,
   input  logic [2:0]  req_target_index,
   input  logic [15:0] req_req_voltage,
   input  logic [15:0] req_req_current,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_request_word,
   output logic        rsp_found,
   output logic [2:0]  rsp_chosen_index,
   output logic [15:0] rsp_granted_voltage,
   output logic [15:0] rsp_granted_current
);
   import pdrb_pkg::*;

   logic [IDX_W-1:0] cap_count_ff, cap_count_in;
   logic [IDX_W-1:0] words_seen_ff, words_seen_in;

   logic                req_acc;
   logic                load;
   logic                room;
   logic                skip;
   logic [IDX_W-1:0]    count_base;
   logic [IDX_W-1:0]    seen_base;
   entry_type           new_entry;
   logic [MAX_CAPS-1:0] wr_en;

   token_type           head_tok;
   token_type           tok_chain [0:MAX_CAPS];
   logic [MAX_CAPS:0]   vld_chain;
   build_status_type    bst;

   assign req_acc   = req_valid && !req_stall;
   assign load      = req_acc && (req_op == OP_LOAD);
   assign req_stall = (|vld_chain[MAX_CAPS:1]) || bst.a_vld || bst.b_vld;

   // a first word restarts the message before it is itself counted
   always_comb begin
      count_base = (load && req_first) ? '0 : cap_count_ff;
      seen_base  = (load && req_first) ? '0 : words_seen_ff;
      room       = seen_base < IDX_W'(MAX_CAPS);
      new_entry  = decode_pdo(req_pdo_word, seen_base + 3'd1);
      // PPS word with reserved bits: use up the position, store nothing
      skip       = (req_pdo_word[31:30] == KIND_PPS) && (|req_pdo_word[29:28]);
      if (load && room) begin
         words_seen_in = seen_base + 3'd1;
         cap_count_in  = skip ? count_base : count_base + 3'd1;
      end else begin
         words_seen_in = seen_base;
         cap_count_in  = count_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_count_ff  <= '0;
         words_seen_ff <= '0;
      end else begin
         cap_count_ff  <= cap_count_in;
         words_seen_ff <= words_seen_in;
      end
   end

   // inject searches and direct requests at the head of the row
   always_comb begin
      head_tok        = '0;
      head_tok.direct = req_op == OP_DIRECT;
      head_tok.tidx   = req_target_index;
      head_tok.v      = req_req_voltage;
      head_tok.i      = req_req_current;
   end

   assign tok_chain[0] = head_tok;
   assign vld_chain[0] = req_acc && ((req_op == OP_SEARCH) || (req_op == OP_DIRECT));

   for (genvar k = 0; k < MAX_CAPS; k++) begin : g_cell
      assign wr_en[k] = load && room && !skip && (count_base == IDX_W'(k));

      pdrb_cell #(
         .CELL_IDX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (wr_en[k]),
         .wr_entry  (new_entry),
         .cap_count (cap_count_ff),
         .in_vld    (vld_chain[k]),
         .in_tok    (tok_chain[k]),
         .out_vld   (vld_chain[k+1]),
         .out_tok   (tok_chain[k+1])
      );
   end

   pdrb_build u_build (
      .clock               (clock),
      .reset               (reset),
      .in_vld              (vld_chain[MAX_CAPS]),
      .in_tok              (tok_chain[MAX_CAPS]),
      .status              (bst),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_request_word    (rsp_request_word),
      .rsp_found           (rsp_found),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_granted_voltage (rsp_granted_voltage),
      .rsp_granted_current (rsp_granted_current)
   );

`ifndef NO_ASSERTIONS
   a_count_le_seen: assert property (@(posedge clock) disable iff (reset)
      cap_count_ff <= words_seen_ff)
      else $error("more entries stored than positions consumed");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      words_seen_ff <= IDX_W'(MAX_CAPS))
      else $error("position count ran past the table size");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      $onehot0({vld_chain[MAX_CAPS:1], bst.a_vld, bst.b_vld}))
      else $error("more than one request in flight");
`endif

endmodule

/* design/pdrb_cell.sv */
module pdrb_cell #(
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  pdrb_pkg::entry_type    wr_entry,
   input  logic [2:0]             cap_count,
   input  logic                   in_vld,
   input  pdrb_pkg::token_type    in_tok,
   output logic                   out_vld,
   output pdrb_pkg::token_type    out_tok
);
   import pdrb_pkg::*;

   entry_type entry_ff;
   logic      vld_ff;
   token_type tok_ff;
   token_type tok_in;

   always_comb begin
      logic live;
      logic vin;
      logic cur_ok;
      live   = IDX_W'(CELL_IDX) < cap_count;
      vin    = (in_tok.v >= entry_ff.vmin) && (in_tok.v <= entry_ff.vmax);
      cur_ok = (in_tok.i == 16'd0) ||
               ((in_tok.i >= MIN_CURRENT) && (in_tok.i <= 16'(entry_ff.imax)));
      tok_in = in_tok;
      if (in_tok.direct) begin
         // direct request: just pick up the named entry
         if (live && (in_tok.tidx == IDX_W'(CELL_IDX))) begin
            tok_in.fix_hit = 1'b1;
            tok_in.fix_idx = IDX_W'(CELL_IDX);
            tok_in.fix_e   = entry_ff;
         end
      end else begin
         // keep the first fixed and the first fitting PPS match
         if (!in_tok.fix_hit && live && vin && (entry_ff.kind == KIND_FIXED)) begin
            tok_in.fix_hit = 1'b1;
            tok_in.fix_idx = IDX_W'(CELL_IDX);
            tok_in.fix_e   = entry_ff;
         end
         if (!in_tok.pps_hit && live && vin && cur_ok && (entry_ff.kind == KIND_PPS)) begin
            tok_in.pps_hit = 1'b1;
            tok_in.pps_idx = IDX_W'(CELL_IDX);
            tok_in.pps_e   = entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
      tok_ff <= tok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   assign out_vld = vld_ff;
   assign out_tok = tok_ff;

endmodule

/* design/pdrb_build.sv */
module pdrb_build (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_vld,
   input  pdrb_pkg::token_type          in_tok,
   output pdrb_pkg::build_status_type   status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [31:0]                  rsp_request_word,
   output logic                         rsp_found,
   output logic [2:0]                   rsp_chosen_index,
   output logic [15:0]                  rsp_granted_voltage,
   output logic [15:0]                  rsp_granted_current
);
   import pdrb_pkg::*;

   // select and check
   logic             a_vld_ff;
   logic             a_ok_ff,  a_ok_in;
   logic             a_pps_ff, a_pps_in;
   logic [2:0]       a_pos_ff, a_pos_in;
   logic [IDX_W-1:0] a_idx_ff, a_idx_in;
   logic [15:0]      a_v_ff;
   logic [CUR_W-1:0] a_xi_ff,  a_xi_in;
   logic [VQ_W-1:0]  a_xv_ff,  a_xv_in;

   // reciprocal products
   logic              b_vld_ff;
   logic              b_ok_ff, b_pps_ff;
   logic [2:0]        b_pos_ff;
   logic [IDX_W-1:0]  b_idx_ff;
   logic [15:0]       b_v_ff;
   logic [PROD_W-1:0] b_pi_ff, b_pi_in;
   logic [PROD_W-1:0] b_pv_ff, b_pv_in;

   logic        out_vld_ff;
   logic [31:0] out_word_ff, out_word_in;
   logic        out_found_ff;
   logic [2:0]  out_idx_ff;
   logic [15:0] out_volt_ff, out_volt_in;
   logic [15:0] out_cur_ff,  out_cur_in;
   logic        out_free;

   always_comb begin
      entry_type  e;
      logic       hit;
      logic [15:0] cur;
      logic       kind_ok;
      if (in_tok.direct || in_tok.fix_hit) begin
         hit      = in_tok.fix_hit;
         e        = in_tok.fix_e;
         a_idx_in = in_tok.fix_idx;
      end else begin
         hit      = in_tok.pps_hit;
         e        = in_tok.pps_e;
         a_idx_in = in_tok.pps_idx;
      end
      // a search with zero current asks for the capability maximum
      cur = (!in_tok.direct && (in_tok.i == 16'd0)) ? 16'(e.imax) : in_tok.i;
      kind_ok  = (e.kind == KIND_FIXED) || (e.kind == KIND_PPS);
      a_ok_in  = hit && kind_ok && (in_tok.v >= e.vmin) && (in_tok.v <= e.vmax) &&
                 (cur >= MIN_CURRENT) && (cur <= 16'(e.imax));
      a_pps_in = e.kind == KIND_PPS;
      a_pos_in = e.pos;
      a_xi_in  = cur[CUR_W-1:0] + (a_pps_in ? RND_50 : RND_10);
      a_xv_in  = in_tok.v[VQ_W-1:0] + RND_20;
   end

   assign b_pi_in = PROD_W'(a_xi_ff) * PROD_W'(a_pps_ff ? RECIP_50 : RECIP_10);
   assign b_pv_in = PROD_W'(a_xv_ff) * PROD_W'(RECIP_20);

   assign out_free = !out_vld_ff || !rsp_stall;

   always_comb begin
      logic [10:0] qraw;
      logic [9:0]  qf;
      logic [6:0]  qp;
      logic [10:0] vq;
      qraw = b_pi_ff[PROD_W-1:RECIP_SHIFT];
      vq   = b_pv_ff[PROD_W-1:RECIP_SHIFT];
      qf   = qraw[10] ? 10'h3ff : qraw[9:0];
      qp   = (|qraw[10:7]) ? 7'h7f : qraw[6:0];
      if (!b_ok_ff) begin
         out_word_in = 32'd0;
         out_volt_in = 16'd0;
         out_cur_in  = 16'd0;
      end else if (b_pps_ff) begin
         out_word_in = {1'b0, b_pos_ff, 4'b0001, 4'b0000, vq, 2'b00, qp};
         out_volt_in = 16'(16'(vq) * 16'd20);
         out_cur_in  = 16'(16'(qp) * 16'd50);
      end else begin
         out_word_in = {1'b0, b_pos_ff, 4'b0001, 4'b0000, qf, qf};
         out_volt_in = b_v_ff;
         out_cur_in  = 16'(16'(qf) * 16'd10);
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld) begin
         a_ok_ff  <= a_ok_in;
         a_pps_ff <= a_pps_in;
         a_pos_ff <= a_pos_in;
         a_idx_ff <= a_idx_in;
         a_v_ff   <= in_tok.v;
         a_xi_ff  <= a_xi_in;
         a_xv_ff  <= a_xv_in;
      end
      if (a_vld_ff) begin
         b_ok_ff  <= a_ok_ff;
         b_pps_ff <= a_pps_ff;
         b_pos_ff <= a_pos_ff;
         b_idx_ff <= a_idx_ff;
         b_v_ff   <= a_v_ff;
         b_pi_ff  <= b_pi_in;
         b_pv_ff  <= b_pv_in;
      end
      if (b_vld_ff && out_free) begin
         out_word_ff  <= out_word_in;
         out_found_ff <= b_ok_ff;
         out_idx_ff   <= b_ok_ff ? b_idx_ff : '0;
         out_volt_ff  <= out_volt_in;
         out_cur_ff   <= out_cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
         // hold the products while the output beat is stalled
         b_vld_ff <= a_vld_ff || (b_vld_ff && !out_free);
         if (b_vld_ff && out_free) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign status.a_vld        = a_vld_ff;
   assign status.b_vld        = b_vld_ff;
   assign rsp_valid           = out_vld_ff;
   assign rsp_request_word    = out_word_ff;
   assign rsp_found           = out_found_ff;
   assign rsp_chosen_index    = out_idx_ff;
   assign rsp_granted_voltage = out_volt_ff;
   assign rsp_granted_current = out_cur_ff;

`ifndef NO_ASSERTIONS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_found_ff) |-> ((out_word_ff == 32'd0) && (out_idx_ff == 3'd0) &&
      (out_volt_ff == 16'd0) && (out_cur_ff == 16'd0)))
      else $error("failed request carries non-zero fields");

   a_found_word: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_found_ff) |-> ((out_word_ff[27:24] == 4'b0001) &&
      (out_word_ff[31:28] != 4'd0)))
      else $error("request word lacks position or no-suspend flag");

   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !out_free) |=> (b_vld_ff && $stable(b_pi_ff) && $stable(b_ok_ff)))
      else $error("product stage dropped a stalled beat");
`endif

endmodule

/* bench/usb_pd_source_cap_request_builder_top_tb.sv */
`timescale 1ns / 100ps

module usb_pd_source_cap_request_builder_top_tb;
   import pdrb_pkg::*;

   localparam int unsigned CAP_SLOTS = 7;
   // Path of a request from the head of the design: walk the row, then select, multiply, output.
   localparam int unsigned LATENCY   = CAP_SLOTS + 3;

   // Supply kinds with no constant of their own in the package.
   localparam logic [1:0] KIND_BATTERY  = 2'd1;
   localparam logic [1:0] KIND_VARIABLE = 2'd2;

   localparam logic [31:0] NO_SUSPEND = 32'h0100_0000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  slot;
      logic [13:0] imax;
      logic [15:0] vmax;
      logic [15:0] vmin;
   } cap_t;

   typedef struct packed {
      logic [31:0] word;
      logic        found;
      logic [2:0]  index;
      logic [15:0] volt;
      logic [15:0] curr;
   } grant_t;

   typedef struct packed {
      logic [1:0]  op;
      logic        first;
      logic [31:0] pdo;
      logic [2:0]  tidx;
      logic [15:0] volt;
      logic [15:0] curr;
      logic        drain;   // hold this beat back until every grant has come home
   } beat_t;

   // Clock, reset and every block input start at known values.
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [1:0]  req_op           = OP_NONE;
   logic        req_first        = 1'b0;
   logic [31:0] req_pdo_word     = '0;
   logic [2:0]  req_target_index = '0;
   logic [15:0] req_req_voltage  = '0;
   logic [15:0] req_req_current  = '0;
   logic        rsp_stall        = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [31:0] rsp_request_word;
   logic        rsp_found;
   logic [2:0]  rsp_chosen_index;
   logic [15:0] rsp_granted_voltage;
   logic [15:0] rsp_granted_current;

   usb_pd_source_cap_request_builder_top #(
      .MAX_CAPS(CAP_SLOTS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_first           (req_first),
      .req_pdo_word        (req_pdo_word),
      .req_target_index    (req_target_index),
      .req_req_voltage     (req_req_voltage),
      .req_req_current     (req_req_current),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_request_word    (rsp_request_word),
      .rsp_found           (rsp_found),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_granted_voltage (rsp_granted_voltage),
      .rsp_granted_current (rsp_granted_current)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow of the capability table and the grant predictor
   // ------------------------------------------------------------------
   cap_t        caps [CAP_SLOTS];
   int unsigned cap_total  = 0;   // entries held
   int unsigned words_used = 0;   // word positions consumed in this message

   beat_t  beat_q [$];            // beats still to be offered
   grant_t grant_q [$];           // grants predicted, oldest first
   beat_t  live_beat;
   int     beat_total   = 0;
   int     beats_taken  = 0;
   int     owed         = 0;      // grants predicted so far
   int     got_count    = 0;      // grants received, updated at the edge
   int     mismatches   = 0;
   int     send_idle    = 35;
   int     recv_idle    = 57;

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Decode one capability word into the shadow table.
   task automatic absorb_cap_word(input logic first, input logic [31:0] w);
      cap_t e;
      if (first) begin
         cap_total  = 0;
         words_used = 0;
      end
      // Drop words past the last kept position.
      if (words_used >= CAP_SLOTS)
         return;
      e.kind = w[31:30];
      e.slot = 3'(words_used + 1);
      e.imax = 14'(w[9:0] * 10);
      e.vmin = 16'(w[19:10] * 50);
      e.vmax = 16'(w[29:20] * 50);
      words_used++;
      if (e.kind == KIND_FIXED) begin
         // Fixed supplies: upper field holds flags, so the range collapses to one voltage.
         e.vmax = e.vmin;
      end else if (e.kind == KIND_PPS) begin
         // Reserved bits set: the position is used up but nothing is stored.
         if (w[29:28] != 2'b00)
            return;
         e.imax = 14'(w[6:0] * 50);
         e.vmin = 16'(w[15:8] * 100);
         e.vmax = 16'(w[24:17] * 100);
      end
      if (cap_total < CAP_SLOTS) begin
         caps[cap_total] = e;
         cap_total++;
      end
   endtask

   // Grant for one table entry; all zero when the entry does not fit.
   function automatic grant_t grant_for(input logic [2:0] idx, input logic [15:0] v,
                                        input logic [15:0] i);
      grant_t      g;
      cap_t        c;
      int unsigned vi, ii, q, vq;
      g  = '0;
      vi = v;
      ii = i;
      if (idx >= cap_total)
         return g;
      c = caps[idx];
      if (c.kind != KIND_FIXED && c.kind != KIND_PPS)
         return g;
      if (vi < c.vmin || vi > c.vmax)
         return g;
      if (ii < MIN_CURRENT || ii > c.imax)
         return g;
      g.word = {1'b0, c.slot, 28'd0} | NO_SUSPEND;
      if (c.kind == KIND_FIXED) begin
         q = (ii + 5) / 10;
         if (q > 'h3ff)
            q = 'h3ff;
         g.word = g.word | (q << 10) | q;
         g.volt = v;
         g.curr = 16'(q * 10);
      end else begin
         vq = (vi + 10) / 20;
         if (vq > 'h7ff)
            vq = 'h7ff;
         q = (ii + 25) / 50;
         if (q > 'h7f)
            q = 'h7f;
         g.word = g.word | (vq << 9) | q;
         g.volt = 16'(vq * 20);
         g.curr = 16'(q * 50);
      end
      g.found = 1'b1;
      g.index = idx;
      return g;
   endfunction

   // Search: first fixed entry on the voltage decides; PPS only when no fixed one matches.
   function automatic grant_t search_grant(input logic [15:0] v, input logic [15:0] i);
      for (int k = 0; k < cap_total; k++)
         if (caps[k].kind == KIND_FIXED && v >= caps[k].vmin && v <= caps[k].vmax)
            return grant_for(3'(k), v, (i == 16'd0) ? 16'(caps[k].imax) : i);
      for (int k = 0; k < cap_total; k++)
         if (caps[k].kind == KIND_PPS && v >= caps[k].vmin && v <= caps[k].vmax) begin
            if (i == 16'd0)
               return grant_for(3'(k), v, 16'(caps[k].imax));
            if (i >= MIN_CURRENT && i <= caps[k].imax)
               return grant_for(3'(k), v, i);
         end
      return '0;
   endfunction

   // Advance the shadow state by one accepted beat.
   task automatic absorb_beat(input beat_t b);
      case (b.op)
         OP_LOAD: absorb_cap_word(b.first, b.pdo);
         OP_SEARCH: begin
            grant_q.push_back(search_grant(b.volt, b.curr));
            owed++;
         end
         OP_DIRECT: begin
            grant_q.push_back(grant_for(b.tidx, b.volt, b.curr));
            owed++;
         end
         default: ;   // unused op: nothing moves
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] seen,
                              input logic [31:0] want);
      if (seen !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h (grant %0d)",
                                   name, seen, want, got_count));
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic beat_t mk_beat(input logic [1:0] op, input logic first,
                                     input logic [31:0] pdo, input logic [2:0] tidx,
                                     input logic [15:0] v, input logic [15:0] i);
      beat_t b;
      b.op    = op;
      b.first = first;
      b.pdo   = pdo;
      b.tidx  = tidx;
      b.volt  = v;
      b.curr  = i;
      b.drain = 1'b0;
      return b;
   endfunction

   // Load beat: the unused fields carry noise so their bits move too.
   function automatic beat_t load_beat(input logic first, input logic [31:0] w);
      return mk_beat(OP_LOAD, first, w, 3'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   // Request beat: first flag and word are noise.
   function automatic beat_t ask_beat(input logic [1:0] op, input logic [2:0] tidx,
                                      input logic [15:0] v, input logic [15:0] i);
      return mk_beat(op, 1'($urandom), $urandom, tidx, v, i);
   endfunction

   function automatic logic [31:0] fixed_pdo(input logic [9:0] v50, input logic [9:0] i10);
      return {KIND_FIXED, 10'($urandom), v50, i10};
   endfunction

   function automatic logic [31:0] pps_pdo(input logic [7:0] vmax100, input logic [7:0] vmin100,
                                           input logic [6:0] i50, input logic [1:0] rsv);
      return {KIND_PPS, rsv, 3'($urandom), vmax100, 1'($urandom), vmin100, 1'($urandom), i50};
   endfunction

   // ------------------------------------------------------------------
   // Fill the beat queue: directed part, then messages with requests aimed at them
   // ------------------------------------------------------------------
   initial begin : stimulus
      int   n_random, nwords, nhint, nask, pick, vmin100, vmax100, hv, hi, vv, ii, tsel;
      int   hint_v [16];
      int   hint_i [16];
      logic [1:0] op;
      beat_t b;

      // Requests against an empty table.
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'd5000, 16'd0));
      beat_q.push_back(ask_beat(OP_DIRECT, 3'd0, 16'd5000, 16'd100));
      // Message of eight words: 5 V with all flag bits set, 9 V, PPS with reserved bit,
      // clean PPS 3.3-11 V, battery, variable, 15 V, and 20 V past the last kept position.
      beat_q.push_back(mk_beat(OP_LOAD, 1'b1, {KIND_FIXED, 10'h3ff, 10'd100, 10'd300},
                               3'd7, 16'hffff, 16'hffff));
      beat_q.push_back(load_beat(1'b0, {KIND_FIXED, 10'h000, 10'd180, 10'd200}));
      beat_q.push_back(load_beat(1'b0, pps_pdo(8'd110, 8'd33, 7'd60, 2'b01)));
      beat_q.push_back(load_beat(1'b0, pps_pdo(8'd110, 8'd33, 7'd60, 2'b00)));
      beat_q.push_back(load_beat(1'b0, {KIND_BATTERY, 10'd400, 10'd100, 10'd200}));
      beat_q.push_back(load_beat(1'b0, {KIND_VARIABLE, 10'd400, 10'd100, 10'd200}));
      beat_q.push_back(load_beat(1'b0, fixed_pdo(10'd300, 10'd100)));
      beat_q.push_back(load_beat(1'b0, fixed_pdo(10'd400, 10'd500)));
      // Table now: 0 5 V, 1 9 V, 2 PPS, 3 battery, 4 variable, 5 15 V.
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'd5000, 16'd0));
      // Fixed 9 V matches but 2.5 A is too much: no fall-through to the PPS entry.
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'd9000, 16'd2500));
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'd7000, 16'd1234));
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'd7010, 16'd0));
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'd7000, 16'd10));
      // Direct request keeps a zero current as zero, and 25 mA is the floor.
      beat_q.push_back(ask_beat(OP_DIRECT, 3'd0, 16'd5000, 16'd0));
      beat_q.push_back(ask_beat(OP_DIRECT, 3'd0, 16'd5000, 16'd25));
      beat_q.push_back(ask_beat(OP_DIRECT, 3'd3, 16'd10000, 16'd1000));
      beat_q.push_back(ask_beat(OP_DIRECT, 3'd7, 16'hffff, 16'hffff));
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'hffff, 16'hffff));
      beat_q.push_back(mk_beat(OP_NONE, 1'b1, 32'hffff_ffff, 3'd7, 16'hffff, 16'hffff));
      beat_q.push_back(ask_beat(OP_DIRECT, 3'd2, 16'd11000, 16'd3000));
      // All-ones word is a PPS with reserved bits; all-zeros word is fixed 0 V, 0 mA.
      beat_q.push_back(load_beat(1'b1, 32'hffff_ffff));
      beat_q.push_back(load_beat(1'b0, 32'h0000_0000));
      beat_q.push_back(ask_beat(OP_SEARCH, 3'd0, 16'd0, 16'd0));
      beat_q.push_back(ask_beat(OP_DIRECT, 3'd0, 16'd0, 16'd25));

      n_random = 0;
      while (n_random < 450) begin
         nwords = $urandom_range(1, 9);
         nhint  = 0;
         for (int w = 0; w < nwords; w++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               hv = chance(85) ? $urandom_range(60, 400) : $urandom_range(0, 1023);
               hi = chance(85) ? $urandom_range(50, 500) : $urandom_range(0, 1023);
               hint_v[nhint] = hv * 50;
               hint_i[nhint] = hi * 10;
               nhint++;
               b = load_beat(1'b0, fixed_pdo(10'(hv), 10'(hi)));
            end else if (pick < 80) begin
               vmin100 = $urandom_range(0, 120);
               vmax100 = vmin100 + $urandom_range(0, 135);
               if (vmax100 > 255)
                  vmax100 = 255;
               hi = $urandom_range(0, 127);
               hint_v[nhint] = $urandom_range(vmin100 * 100, vmax100 * 100);
               hint_i[nhint] = hi * 50;
               nhint++;
               b = load_beat(1'b0, pps_pdo(8'(vmax100), 8'(vmin100), 7'(hi),
                                           chance(10) ? 2'($urandom_range(1, 3)) : 2'b00));
            end else if (pick < 90) begin
               b = load_beat(1'b0, {chance(50) ? KIND_BATTERY : KIND_VARIABLE, 30'($urandom)});
            end else begin
               b = load_beat(1'b0, $urandom);
            end
            // Mostly a proper message start; sometimes a message runs on past seven words.
            b.first = (w == 0) ? chance(90) : chance(3);
            beat_q.push_back(b);
            n_random++;
         end

         nask = $urandom_range(1, 6);
         for (int r = 0; r < nask; r++) begin
            op = chance(30) ? OP_DIRECT : OP_SEARCH;
            if (nhint > 0 && chance(80)) begin
               tsel = $urandom_range(0, nhint - 1);
               hv   = hint_v[tsel];
               hi   = hint_i[tsel];
               pick = $urandom_range(9);
               vv   = (pick < 6) ? hv : (pick < 9) ? hv + $urandom_range(0, 98) - 49
                                                   : $urandom_range(0, 65535);
               pick = $urandom_range(9);
               case (pick)
                  0:       ii = 0;
                  1:       ii = hi;
                  2:       ii = hi + 1;
                  3:       ii = 24;
                  4:       ii = 25;
                  5:       ii = $urandom_range(0, 65535);
                  default: ii = $urandom_range(0, hi);
               endcase
            end else begin
               vv = $urandom_range(0, 65535);
               ii = chance(50) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
            end
            if (vv < 0)
               vv = 0;
            if (vv > 65535)
               vv = 65535;
            if (ii > 65535)
               ii = 65535;
            b = ask_beat(op, chance(80) ? 3'($urandom_range(0, nwords > 7 ? 6 : nwords - 1))
                                        : 3'($urandom_range(0, 7)),
                         16'(vv), 16'(ii));
            // A few unused ops in the stream; they do not count towards the total.
            if (chance(5))
               b.op = OP_NONE;
            else
               n_random++;
            beat_q.push_back(b);
         end
         // Now and then let everything drain before the next message starts.
         if (chance(5) && beat_q.size() != 0)
            beat_q[beat_q.size() - 1].drain = 1'b1;
      end
      // Hold the first random beat until the directed grants are all back.
      beat_q[26].drain = 1'b1;
      beat_total = beat_q.size();
   end

   // ------------------------------------------------------------------
   // Driver: offer beats from the queue, hold the payload while stalled
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      beat_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_beat(live_beat);
            beats_taken++;
         end
         // Idle mix by third of the run: sender heavy, then receiver heavy, then none.
         if (beats_taken * 3 < beat_total) begin
            send_idle <= 35;
            recv_idle <= 57;
         end else if (beats_taken * 3 < beat_total * 2) begin
            send_idle <= 57;
            recv_idle <= 35;
         end else begin
            send_idle <= 0;
            recv_idle <= 0;
         end
         // The slot is free once the last beat went in or nothing was offered.
         if (!req_valid || !req_stall) begin
            if (beat_q.size() != 0 && !(beat_q[0].drain && got_count != owed) &&
                !chance(send_idle)) begin
               nxt       = beat_q.pop_front();
               live_beat = nxt;
               req_valid        <= 1'b1;
               req_op           <= nxt.op;
               req_first        <= nxt.first;
               req_pdo_word     <= nxt.pdo;
               req_target_index <= nxt.tidx;
               req_req_voltage  <= nxt.volt;
               req_req_current  <= nxt.curr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each response beat with the oldest predicted grant
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      grant_t want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_count <= got_count + 1;
            if (grant_q.size() == 0) begin
               report_mismatch("response beat with no grant outstanding");
            end else begin
               want = grant_q.pop_front();
               check_field("request_word", rsp_request_word, want.word);
               check_field("found", 32'(rsp_found), 32'(want.found));
               check_field("chosen_index", 32'(rsp_chosen_index), 32'(want.index));
               check_field("granted_voltage", 32'(rsp_granted_voltage), 32'(want.volt));
               check_field("granted_current", 32'(rsp_granted_current), 32'(want.curr));
            end
         end
         rsp_stall <= chance(recv_idle);
      end
   end

   // ------------------------------------------------------------------
   // Reset, end of run and verdict
   // ------------------------------------------------------------------
   initial begin : sequencer
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Wait for every beat to go in, then for every grant to come back.
      while (beat_total == 0 || beat_q.size() != 0 || req_valid)
         @(posedge clock);
      while (got_count != owed)
         @(posedge clock);
      // Let any stray response surface.
      repeat (4 * LATENCY) @(posedge clock);
      if (grant_q.size() != 0)
         report_mismatch($sformatf("%0d grants never arrived", grant_q.size()));
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
